// ===== design/npc_pkg.sv =====
// Shared widths, coefficients and constant tables for the normal density/CDF pipeline.
`timescale 1ns / 1ps
package npc_pkg;

  localparam int IN_FRAC_BITS  = 12;
  localparam int OUT_FRAC_BITS = 16;

  localparam int X_W    = 24;
  localparam int SIG_W  = 23;
  localparam int DENS_W = 24;
  localparam int CUM_W  = 17;

  localparam int ZF     = 16;
  localparam int Z_W    = 20;
  localparam int W_W    = 23;
  localparam int P_W    = 31;
  localparam int PHI_W  = 29;
  localparam int DEN_W  = 33;
  localparam int T_W    = 31;
  localparam int ACC_W  = 33;
  localparam int POLY_W = 31;
  localparam int NSTEP  = 5;

  localparam logic             REG_MEAN  = 1'b0;
  localparam logic             REG_SIGMA = 1'b1;

  localparam logic [Z_W-1:0]   ZMAX      = {Z_W{1'b1}};
  localparam logic [P_W-1:0]   QONE      = 31'h4000_0000;
  localparam logic [27:0]      COEF_B0   = 28'd248723596;
  localparam logic [PHI_W-1:0] INV_SQRT_2PI = 29'd428361012;
  localparam logic signed [ACC_W-1:0] COEF_B5 = 33'sd1428371292;
  localparam logic signed [ACC_W-1:0] HCOEF [NSTEP] = '{
    -33'sd1955558716, 33'sd1912847369, -33'sd382857446, 33'sd342933307, 33'sd0
  };

  // exp(-2^-s) in Q30 from a Q60 alternating Taylor sum
  function automatic logic [63:0] exp_taylor(int s);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'h1000_0000_0000_0000;
    pos  = term;
    neg  = '0;
    term = (term >> s) / 64'd1;  neg = neg + term;
    term = (term >> s) / 64'd2;  pos = pos + term;
    term = (term >> s) / 64'd3;  neg = neg + term;
    term = (term >> s) / 64'd4;  pos = pos + term;
    term = (term >> s) / 64'd5;  neg = neg + term;
    term = (term >> s) / 64'd6;  pos = pos + term;
    term = (term >> s) / 64'd7;  neg = neg + term;
    term = (term >> s) / 64'd8;  pos = pos + term;
    term = (term >> s) / 64'd9;  neg = neg + term;
    term = (term >> s) / 64'd10; pos = pos + term;
    term = (term >> s) / 64'd11; neg = neg + term;
    term = (term >> s) / 64'd12; pos = pos + term;
    term = (term >> s) / 64'd13; neg = neg + term;
    term = (term >> s) / 64'd14; pos = pos + term;
    term = (term >> s) / 64'd15; neg = neg + term;
    term = (term >> s) / 64'd16; pos = pos + term;
    term = (term >> s) / 64'd17; neg = neg + term;
    term = (term >> s) / 64'd18; pos = pos + term;
    term = (term >> s) / 64'd19; neg = neg + term;
    term = (term >> s) / 64'd20; pos = pos + term;
    term = (term >> s) / 64'd21; neg = neg + term;
    term = (term >> s) / 64'd22; pos = pos + term;
    term = (term >> s) / 64'd23; neg = neg + term;
    term = (term >> s) / 64'd24; pos = pos + term;
    return ((pos - neg) + 64'h2000_0000) >> 30;
  endfunction

  // exp(-2^(k-16)) in Q30; entries for k > 16 are rounded squares
  function automatic logic [P_W-1:0] exp_tab(int k);
    logic [63:0] v;
    int j;
    if (k <= 16) begin
      v = exp_taylor(16 - k);
    end else begin
      v = exp_taylor(0);
      for (j = 17; j <= k; j++) begin
        v = (v * v + 64'h2000_0000) >> 30;
      end
    end
    return v[P_W-1:0];
  endfunction

endpackage

// ===== design/normal_pdf_cdf_approx.sv =====
// Pipelined normal density and cumulative probability evaluator (A&S 26.2.17).
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_x                                    | start & !busy
//  result  | out_density, out_cumulative             | out_valid, one-cycle strobe
//  config  | cfg_index, cfg_wdata                    | cfg_we
//
// One beat enters per cycle; busy stays low. Each result passes through the three
// restoring dividers (20, 31 and 24 stages), the 23-stage exp product chain and
// the 10-stage polynomial. rst_n clears valid bits and loads mean = 0, sigma = 1.0.
// The receiver cannot stall the pipe.
`timescale 1ns / 1ps
module normal_pdf_cdf_approx #(
  parameter int IN_FRAC_BITS  = npc_pkg::IN_FRAC_BITS,
  parameter int OUT_FRAC_BITS = npc_pkg::OUT_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [npc_pkg::X_W-1:0]    in_x,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [npc_pkg::X_W-1:0]           cfg_wdata,
  output logic                              out_valid,
  output logic [npc_pkg::DENS_W-1:0]        out_density,
  output logic [npc_pkg::CUM_W-1:0]         out_cumulative
);

  localparam int X_W    = npc_pkg::X_W;
  localparam int SIG_W  = npc_pkg::SIG_W;
  localparam int Z_W    = npc_pkg::Z_W;
  localparam int W_W    = npc_pkg::W_W;
  localparam int P_W    = npc_pkg::P_W;
  localparam int PHI_W  = npc_pkg::PHI_W;
  localparam int DEN_W  = npc_pkg::DEN_W;
  localparam int T_W    = npc_pkg::T_W;
  localparam int ACC_W  = npc_pkg::ACC_W;
  localparam int POLY_W = npc_pkg::POLY_W;
  localparam int NSTEP  = npc_pkg::NSTEP;
  localparam int DENS_W = npc_pkg::DENS_W;
  localparam int CUM_W  = npc_pkg::CUM_W;
  localparam int ZF     = npc_pkg::ZF;
  localparam int LO_W   = X_W - Z_W;

  localparam int SH     = 30 - OUT_FRAC_BITS;
  localparam int DW     = SIG_W + SH;
  localparam int NA     = PHI_W + IN_FRAC_BITS;
  localparam int NB     = SIG_W + SH - 1;
  localparam int NW     = ((NA > NB) ? NA : NB) + 1;
  localparam int HW     = NW - DENS_W;
  localparam int CW     = (HW > DW) ? HW : DW;
  localparam logic [31:0] CHALF = 32'(1) << (SH - 1);
  localparam logic [31:0] CMAX  = ((32'(1) << OUT_FRAC_BITS) > 32'h1FFFF) ?
                                  32'h1FFFF : (32'(1) << OUT_FRAC_BITS);

  // ---------------- configuration ----------------
  logic signed [X_W-1:0] mean_r;
  logic [SIG_W-1:0]      sigma_r;
  logic [SIG_W-1:0]      sg;
  logic [DW-1:0]         dd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= '0;
      sigma_r <= SIG_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        npc_pkg::REG_MEAN:  mean_r  <= cfg_wdata;
        npc_pkg::REG_SIGMA: sigma_r <= cfg_wdata[SIG_W-1:0];
        default: ;
      endcase
    end
  end

  assign sg   = (sigma_r == '0) ? SIG_W'(1) : sigma_r;
  assign dd   = DW'(sg) << SH;
  assign busy = 1'b0;

  // ---------------- difference and magnitude ----------------
  logic signed [X_W:0] diff;
  logic                s1_v_r, s1_neg_r;
  logic [X_W-1:0]      s1_ad_r;

  assign diff = {in_x[X_W-1], in_x} - {mean_r[X_W-1], mean_r};

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= start;
    s1_neg_r <= diff[X_W];
    s1_ad_r  <= diff[X_W] ? X_W'(-diff) : X_W'(diff);
  end

  logic           s2_v_r, s2_neg_r, s2_ovf_r;
  logic [X_W-1:0] s2_ad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
    s2_neg_r <= s1_neg_r;
    s2_ad_r  <= s1_ad_r;
    s2_ovf_r <= SIG_W'(s1_ad_r[X_W-1:LO_W]) >= sg;
  end

  // ---------------- |z| = (|d| << 16) / sigma, one bit per stage ----------------
  logic             z_v_r   [Z_W];
  logic             z_neg_r [Z_W];
  logic             z_ovf_r [Z_W];
  logic [LO_W-1:0]  z_lo_r  [Z_W];
  logic [SIG_W-1:0] z_rem_r [Z_W];
  logic [Z_W-1:0]   z_q_r   [Z_W];

  for (genvar i = 0; i < Z_W; i++) begin : g_zdiv
    logic             v_in, neg_in, ovf_in, bitv, ge;
    logic [LO_W-1:0]  lo_in;
    logic [SIG_W-1:0] rem_in;
    logic [Z_W-1:0]   q_in;
    logic [SIG_W:0]   trial;
    if (i == 0) begin : g_first
      assign v_in   = s2_v_r;
      assign neg_in = s2_neg_r;
      assign ovf_in = s2_ovf_r;
      assign lo_in  = s2_ad_r[LO_W-1:0];
      assign rem_in = SIG_W'(s2_ad_r[X_W-1:LO_W]);
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = z_v_r[i-1];
      assign neg_in = z_neg_r[i-1];
      assign ovf_in = z_ovf_r[i-1];
      assign lo_in  = z_lo_r[i-1];
      assign rem_in = z_rem_r[i-1];
      assign q_in   = z_q_r[i-1];
    end
    if (i < LO_W) begin : g_bit
      assign bitv = lo_in[LO_W-1-i];
    end else begin : g_zero
      assign bitv = 1'b0;
    end
    assign trial = {rem_in, bitv};
    assign ge    = trial >= {1'b0, sg};
    always_ff @(posedge clk) begin
      if (!rst_n) z_v_r[i] <= 1'b0;
      else        z_v_r[i] <= v_in;
      z_neg_r[i] <= neg_in;
      z_ovf_r[i] <= ovf_in;
      z_lo_r[i]  <= lo_in;
      z_rem_r[i] <= ge ? SIG_W'(trial - {1'b0, sg}) : trial[SIG_W-1:0];
      z_q_r[i]   <= {q_in[Z_W-2:0], ge};
    end
  end

  // ---------------- z^2 and b0*|z| ----------------
  logic [Z_W-1:0]   az;
  logic             m_v_r, m_neg_r;
  logic [2*Z_W-1:0] m_sq_r;
  logic [47:0]      m_bz_r;

  assign az = z_ovf_r[Z_W-1] ? npc_pkg::ZMAX : z_q_r[Z_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else        m_v_r <= z_v_r[Z_W-1];
    m_neg_r <= z_neg_r[Z_W-1];
    m_sq_r  <= {{Z_W{1'b0}}, az} * {{Z_W{1'b0}}, az};
    m_bz_r  <= {28'b0, az} * {20'b0, npc_pkg::COEF_B0};
  end

  logic [2*Z_W:0]   sq_rnd;
  logic [48:0]      bz_rnd;
  logic             wd_v_r, wd_neg_r;
  logic [W_W-1:0]   wd_w_r;
  logic [DEN_W-1:0] wd_den_r;

  assign sq_rnd = {1'b0, m_sq_r} + (41'(1) << ZF);
  assign bz_rnd = {1'b0, m_bz_r} + (49'(1) << (ZF - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) wd_v_r <= 1'b0;
    else        wd_v_r <= m_v_r;
    wd_neg_r <= m_neg_r;
    wd_w_r   <= sq_rnd[W_W+ZF:ZF+1];
    wd_den_r <= DEN_W'(npc_pkg::QONE) + bz_rnd[48:ZF];
  end

  // ---------------- exp(-w): one table factor per stage ----------------
  logic             e_v_r   [W_W];
  logic             e_neg_r [W_W];
  logic [W_W-1:0]   e_w_r   [W_W];
  logic [DEN_W-1:0] e_den_r [W_W];
  logic [P_W-1:0]   e_p_r   [W_W];

  for (genvar i = 0; i < W_W; i++) begin : g_exp
    localparam logic [P_W-1:0] TAB = npc_pkg::exp_tab(i);
    logic             v_in, neg_in;
    logic [W_W-1:0]   w_in;
    logic [DEN_W-1:0] den_in;
    logic [P_W-1:0]   p_in;
    logic [2*P_W-1:0] prod;
    if (i == 0) begin : g_first
      assign v_in   = wd_v_r;
      assign neg_in = wd_neg_r;
      assign w_in   = wd_w_r;
      assign den_in = wd_den_r;
      assign p_in   = npc_pkg::QONE;
    end else begin : g_next
      assign v_in   = e_v_r[i-1];
      assign neg_in = e_neg_r[i-1];
      assign w_in   = e_w_r[i-1];
      assign den_in = e_den_r[i-1];
      assign p_in   = e_p_r[i-1];
    end
    assign prod = {{P_W{1'b0}}, p_in} * {{P_W{1'b0}}, TAB} + (62'(1) << 29);
    always_ff @(posedge clk) begin
      if (!rst_n) e_v_r[i] <= 1'b0;
      else        e_v_r[i] <= v_in;
      e_neg_r[i] <= neg_in;
      e_w_r[i]   <= w_in;
      e_den_r[i] <= den_in;
      e_p_r[i]   <= w_in[i] ? prod[P_W+29:30] : p_in;
    end
  end

  logic [60:0]      phi_prod;
  logic             ph_v_r, ph_neg_r;
  logic [PHI_W-1:0] ph_phi_r;
  logic [DEN_W-1:0] ph_den_r;

  assign phi_prod = {30'b0, e_p_r[W_W-1]} * {32'b0, npc_pkg::INV_SQRT_2PI} + (61'(1) << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) ph_v_r <= 1'b0;
    else        ph_v_r <= e_v_r[W_W-1];
    ph_neg_r <= e_neg_r[W_W-1];
    ph_den_r <= e_den_r[W_W-1];
    ph_phi_r <= phi_prod[PHI_W+29:30];
  end

  // ---------------- t = 2^60 / denom, one bit per stage ----------------
  logic             t_v_r   [T_W];
  logic             t_neg_r [T_W];
  logic [PHI_W-1:0] t_phi_r [T_W];
  logic [DEN_W-1:0] t_den_r [T_W];
  logic [DEN_W-1:0] t_rem_r [T_W];
  logic [T_W-1:0]   t_q_r   [T_W];

  for (genvar i = 0; i < T_W; i++) begin : g_tdiv
    logic             v_in, neg_in, ge;
    logic [PHI_W-1:0] phi_in;
    logic [DEN_W-1:0] den_in, rem_in;
    logic [T_W-1:0]   q_in;
    logic [DEN_W:0]   trial;
    if (i == 0) begin : g_first
      assign v_in   = ph_v_r;
      assign neg_in = ph_neg_r;
      assign phi_in = ph_phi_r;
      assign den_in = ph_den_r;
      assign rem_in = DEN_W'(1) << 29;
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = t_v_r[i-1];
      assign neg_in = t_neg_r[i-1];
      assign phi_in = t_phi_r[i-1];
      assign den_in = t_den_r[i-1];
      assign rem_in = t_rem_r[i-1];
      assign q_in   = t_q_r[i-1];
    end
    assign trial = {rem_in, 1'b0};
    assign ge    = trial >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (!rst_n) t_v_r[i] <= 1'b0;
      else        t_v_r[i] <= v_in;
      t_neg_r[i] <= neg_in;
      t_phi_r[i] <= phi_in;
      t_den_r[i] <= den_in;
      t_rem_r[i] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      t_q_r[i]   <= {q_in[T_W-2:0], ge};
    end
  end

  // ---------------- Horner steps: multiply stage, then round and add ----------------
  logic                    ha_v_r   [NSTEP];
  logic                    ha_neg_r [NSTEP];
  logic                    ha_sn_r  [NSTEP];
  logic [PHI_W-1:0]        ha_phi_r [NSTEP];
  logic [T_W-1:0]          ha_t_r   [NSTEP];
  logic [62:0]             ha_pr_r  [NSTEP];
  logic                    hb_v_r   [NSTEP];
  logic                    hb_neg_r [NSTEP];
  logic [PHI_W-1:0]        hb_phi_r [NSTEP];
  logic [T_W-1:0]          hb_t_r   [NSTEP];
  logic signed [ACC_W-1:0] hb_acc_r [NSTEP];

  for (genvar k = 0; k < NSTEP; k++) begin : g_horner
    logic                    v_in, neg_in;
    logic [PHI_W-1:0]        phi_in;
    logic [T_W-1:0]          t_in;
    logic signed [ACC_W-1:0] acc_in;
    logic [ACC_W-2:0]        mag;
    logic [62:0]             rnd;
    logic [ACC_W-1:0]        r;
    logic signed [ACC_W-1:0] sr;
    if (k == 0) begin : g_first
      assign v_in   = t_v_r[T_W-1];
      assign neg_in = t_neg_r[T_W-1];
      assign phi_in = t_phi_r[T_W-1];
      assign t_in   = t_q_r[T_W-1];
      assign acc_in = npc_pkg::COEF_B5;
    end else begin : g_next
      assign v_in   = hb_v_r[k-1];
      assign neg_in = hb_neg_r[k-1];
      assign phi_in = hb_phi_r[k-1];
      assign t_in   = hb_t_r[k-1];
      assign acc_in = hb_acc_r[k-1];
    end
    assign mag = acc_in[ACC_W-1] ? (ACC_W-1)'(-acc_in) : acc_in[ACC_W-2:0];
    assign rnd = ha_pr_r[k] + (63'(1) << 29);
    assign r   = rnd[62:30];
    assign sr  = ha_sn_r[k] ? -$signed(r) : $signed(r);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ha_v_r[k] <= 1'b0;
        hb_v_r[k] <= 1'b0;
      end else begin
        ha_v_r[k] <= v_in;
        hb_v_r[k] <= ha_v_r[k];
      end
      ha_neg_r[k] <= neg_in;
      ha_phi_r[k] <= phi_in;
      ha_t_r[k]   <= t_in;
      ha_sn_r[k]  <= acc_in[ACC_W-1];
      ha_pr_r[k]  <= {31'b0, mag} * {32'b0, t_in};
      hb_neg_r[k] <= ha_neg_r[k];
      hb_phi_r[k] <= ha_phi_r[k];
      hb_t_r[k]   <= ha_t_r[k];
      hb_acc_r[k] <= npc_pkg::HCOEF[k] + sr;
    end
  end

  // ---------------- tail product and density dividend ----------------
  logic signed [ACC_W-1:0] acc_last;
  logic [POLY_W-1:0]       poly;
  logic                    tl_v_r, tl_neg_r;
  logic [PHI_W+POLY_W-1:0] tl_prod_r;
  logic [NW-1:0]           tl_nd_r;

  assign acc_last = hb_acc_r[NSTEP-1];
  assign poly     = acc_last[ACC_W-1] ? '0 : acc_last[POLY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) tl_v_r <= 1'b0;
    else        tl_v_r <= hb_v_r[NSTEP-1];
    tl_neg_r  <= hb_neg_r[NSTEP-1];
    tl_prod_r <= {{POLY_W{1'b0}}, hb_phi_r[NSTEP-1]} * {{PHI_W{1'b0}}, poly};
    tl_nd_r   <= (NW'(hb_phi_r[NSTEP-1]) << IN_FRAC_BITS) + (NW'(sg) << (SH - 1));
  end

  logic [PHI_W+POLY_W:0] tail_rnd;
  logic [P_W-1:0]        tail;
  logic [HW-1:0]         nd_hi;
  logic                  c1_v_r, c1_ovf_r;
  logic [P_W-1:0]        c1_cpre_r;
  logic [DENS_W-1:0]     c1_lo_r;
  logic [DW-1:0]         c1_rem_r;

  assign tail_rnd = {1'b0, tl_prod_r} + 61'(64'(1) << 29);
  assign tail     = (tail_rnd[PHI_W+POLY_W:30] > 31'(npc_pkg::QONE)) ?
                    npc_pkg::QONE : P_W'(tail_rnd[PHI_W+POLY_W:30]);
  assign nd_hi    = tl_nd_r[NW-1:DENS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) c1_v_r <= 1'b0;
    else        c1_v_r <= tl_v_r;
    c1_cpre_r <= tl_neg_r ? tail : (npc_pkg::QONE - tail);
    c1_ovf_r  <= CW'(nd_hi) >= CW'(dd);
    c1_lo_r   <= tl_nd_r[DENS_W-1:0];
    c1_rem_r  <= DW'(nd_hi);
  end

  logic [31:0]       cum_rnd;
  logic              c2_v_r, c2_ovf_r;
  logic [CUM_W-1:0]  c2_cum_r;
  logic [DENS_W-1:0] c2_lo_r;
  logic [DW-1:0]     c2_rem_r;

  assign cum_rnd = (32'(c1_cpre_r) + CHALF) >> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) c2_v_r <= 1'b0;
    else        c2_v_r <= c1_v_r;
    c2_cum_r <= (cum_rnd > CMAX) ? CMAX[CUM_W-1:0] : cum_rnd[CUM_W-1:0];
    c2_ovf_r <= c1_ovf_r;
    c2_lo_r  <= c1_lo_r;
    c2_rem_r <= c1_rem_r;
  end

  // ---------------- density = dividend / (sigma << SH), one bit per stage ----------------
  logic              dv_v_r   [DENS_W];
  logic              dv_ovf_r [DENS_W];
  logic [CUM_W-1:0]  dv_cum_r [DENS_W];
  logic [DENS_W-1:0] dv_lo_r  [DENS_W];
  logic [DW-1:0]     dv_rem_r [DENS_W];
  logic [DENS_W-1:0] dv_q_r   [DENS_W];

  for (genvar i = 0; i < DENS_W; i++) begin : g_ddiv
    logic              v_in, ovf_in, ge;
    logic [CUM_W-1:0]  cum_in;
    logic [DENS_W-1:0] lo_in, q_in;
    logic [DW-1:0]     rem_in;
    logic [DW:0]       trial;
    if (i == 0) begin : g_first
      assign v_in   = c2_v_r;
      assign ovf_in = c2_ovf_r;
      assign cum_in = c2_cum_r;
      assign lo_in  = c2_lo_r;
      assign rem_in = c2_rem_r;
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = dv_v_r[i-1];
      assign ovf_in = dv_ovf_r[i-1];
      assign cum_in = dv_cum_r[i-1];
      assign lo_in  = dv_lo_r[i-1];
      assign rem_in = dv_rem_r[i-1];
      assign q_in   = dv_q_r[i-1];
    end
    assign trial = {rem_in, lo_in[DENS_W-1-i]};
    assign ge    = trial >= {1'b0, dd};
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[i] <= 1'b0;
      else        dv_v_r[i] <= v_in;
      dv_ovf_r[i] <= ovf_in;
      dv_cum_r[i] <= cum_in;
      dv_lo_r[i]  <= lo_in;
      dv_rem_r[i] <= ge ? DW'(trial - {1'b0, dd}) : trial[DW-1:0];
      dv_q_r[i]   <= {q_in[DENS_W-2:0], ge};
    end
  end

  // ---------------- output register ----------------
  logic              out_v_r;
  logic [DENS_W-1:0] out_dens_r;
  logic [CUM_W-1:0]  out_cum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else        out_v_r <= dv_v_r[DENS_W-1];
    out_dens_r <= dv_ovf_r[DENS_W-1] ? {DENS_W{1'b1}} : dv_q_r[DENS_W-1];
    out_cum_r  <= dv_cum_r[DENS_W-1];
  end

  assign out_valid      = out_v_r;
  assign out_density    = out_dens_r;
  assign out_cumulative = out_cum_r;

endmodule
